>>> rtl/core/iirt2_pkg.sv
// ----------------------------------------------------------------------------
// iirt2_pkg
// Types and constants shared by the transposed direct form II IIR core.
// ----------------------------------------------------------------------------
package iirt2_pkg;

  localparam int MAX_TAPS    = 8;
  localparam int TAP_W       = $clog2(MAX_TAPS);
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 24;
  localparam int COEF_FRAC   = COEF_BITS - 4;
  localparam int STATE_BITS  = 48;
  localparam int ACC_W       = STATE_BITS + 2;
  localparam int QUO_W       = SAMPLE_BITS + 1;
  localparam int REM_W       = COEF_BITS + QUO_W;
  localparam int NUM_W       = ACC_W + 1;
  localparam int TERM_W      = COEF_BITS + 1;
  localparam int BIT_W       = $clog2(SAMPLE_BITS);
  localparam int NTAPS_W     = 4;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_WR_B   = 2'd1,
    CMD_WR_A   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ACC,
    ST_DIVPRE,
    ST_DIV,
    ST_YFIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t                          cmd;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [2:0]                    coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          saturated;
    logic                          div_by_zero;
  } out_req_t;

endpackage

>>> rtl/core/iir_filter_tdf2_core.sv
// ----------------------------------------------------------------------------
// iir_filter_tdf2_core
// Fixed-point IIR filter, transposed direct form II, bit-serial MAC and divide.
// ----------------------------------------------------------------------------
// Each sample runs the bit-serial MAC over len = num_taps clamped to 1..8 taps and a
//   restoring divide by a0 for 17 quotient bits; the bit-by-bit divide steps are skipped
//   when the quotient is known to clip, and the whole divide is skipped if a0 is 0.
//   Requests are taken only in idle, so a new one waits until the previous sample is done.
// A result still held at the output stalls the next sample in its last cycle.
// Reset: b all zero, a0 = 1.0, other a zero, delay line zero, num_taps 1.
module iir_filter_tdf2_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  iirt2_pkg::in_req_t       in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output iirt2_pkg::out_req_t      out_data,
  input  logic                     cfg_we,
  input  logic [iirt2_pkg::NTAPS_W-1:0] cfg_wdata
);
  import iirt2_pkg::*;

  localparam logic signed [ACC_W-1:0] ZMAX = ACC_W'((64'sd1 <<< (STATE_BITS-1)) - 1);
  localparam logic signed [ACC_W-1:0] ZMIN = -ZMAX - ACC_W'(1);

  state_t state_r, state_nxt;

  logic [NTAPS_W-1:0]            ntaps_r;
  logic signed [COEF_BITS-1:0]   b_r [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   a_r [MAX_TAPS];
  logic signed [STATE_BITS-1:0]  z_r [MAX_TAPS];

  logic signed [SAMPLE_BITS-1:0] x_r, y_r, xs_r, ys_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic [BIT_W-1:0]              cnt_r;
  logic [TAP_W-1:0]              tap_r;
  logic [QUO_W-1:0]              q_r;
  logic [REM_W-1:0]              rem_r, dsh_r;
  logic [COEF_BITS-1:0]          ud_r;
  logic                          neg_r, sat_r, dz_r;
  logic                          out_valid_r;
  out_req_t                      out_r;

  logic [TAP_W:0]                len;
  logic                          accept;
  logic                          load_out;
  logic signed [TERM_W-1:0]      term;
  logic signed [ACC_W-1:0]       mac_nxt, sum;
  logic [ACC_W-1:0]              un;
  logic [COEF_BITS-1:0]          ud;
  logic [NUM_W-1:0]              nval;
  logic [REM_W-1:0]              nrem, dtop;
  logic [QUO_W-1:0]              qc;

  always_comb begin
    if (ntaps_r == '0) begin
      len = (TAP_W+1)'(1);
    end else if (ntaps_r > NTAPS_W'(MAX_TAPS)) begin
      len = (TAP_W+1)'(MAX_TAPS);
    end else begin
      len = (TAP_W+1)'(ntaps_r);
    end
  end

  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    term = (xs_r[SAMPLE_BITS-1] ? TERM_W'(b_r[tap_r]) : '0)
         - (ys_r[SAMPLE_BITS-1] ? TERM_W'(a_r[tap_r]) : '0);
    if (cnt_r == '0) begin
      mac_nxt = (acc_r <<< 1) - ACC_W'(term);
    end else begin
      mac_nxt = (acc_r <<< 1) + ACC_W'(term);
    end
    sum  = acc_r + ACC_W'(z_r[tap_r]);
    un   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    ud   = a_r[0][COEF_BITS-1] ? COEF_BITS'(-a_r[0]) : COEF_BITS'(a_r[0]);
    nval = NUM_W'(un) + NUM_W'(ud >> 1);
    nrem = REM_W'(nval);
    dtop = REM_W'({ud_r, (QUO_W-1)'(0)});
    qc   = q_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_data.cmd == CMD_SAMPLE) state_nxt = ST_MAC;
      end
      ST_MAC: begin
        if (cnt_r == BIT_W'(SAMPLE_BITS-1)) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (tap_r == '0) begin
          state_nxt = (a_r[0] == '0) ? ST_YFIX : ST_DIVPRE;
        end else if ((TAP_W+1)'(tap_r) + 1'b1 < len) begin
          state_nxt = ST_MAC;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIVPRE: begin
        if (nval >= NUM_W'({ud_r, QUO_W'(0)})) state_nxt = ST_YFIX;
        else state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == '0) state_nxt = ST_YFIX;
      end
      ST_YFIX: begin
        state_nxt = (len > (TAP_W+1)'(1)) ? ST_MAC : ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = out_valid_r;
    out_data  = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ntaps_r     <= NTAPS_W'(1);
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      for (int i = 0; i < MAX_TAPS; i++) begin
        b_r[i] <= '0;
        a_r[i] <= (i == 0) ? COEF_BITS'(1 << COEF_FRAC) : '0;
        z_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) ntaps_r <= cfg_wdata;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_data.cmd)
              CMD_WR_B: b_r[in_data.coef_index] <= in_data.coef_value;
              CMD_WR_A: a_r[in_data.coef_index] <= in_data.coef_value;
              CMD_CLEAR: begin
                for (int i = 0; i < MAX_TAPS; i++) z_r[i] <= '0;
              end
              CMD_SAMPLE: begin
                for (int i = 0; i < MAX_TAPS; i++) begin
                  if ((TAP_W+1)'(i) + 1'b1 >= len) z_r[i] <= '0;
                end
                x_r   <= in_data.sample_in;
                xs_r  <= in_data.sample_in;
                y_r   <= '0;
                ys_r  <= '0;
                acc_r <= '0;
                tap_r <= '0;
                cnt_r <= '0;
                sat_r <= 1'b0;
                dz_r  <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_MAC: begin
          acc_r <= mac_nxt;
          xs_r  <= xs_r <<< 1;
          ys_r  <= ys_r <<< 1;
          cnt_r <= cnt_r + 1'b1;
        end
        ST_ACC: begin
          if (tap_r == '0) begin
            acc_r <= sum;
            if (a_r[0] == '0) begin
              dz_r  <= 1'b1;
              q_r   <= '0;
              neg_r <= 1'b0;
            end
          end else begin
            if (sum > ZMAX) begin
              z_r[tap_r - 1'b1] <= STATE_BITS'(ZMAX);
              sat_r <= 1'b1;
            end else if (sum < ZMIN) begin
              z_r[tap_r - 1'b1] <= STATE_BITS'(ZMIN);
              sat_r <= 1'b1;
            end else begin
              z_r[tap_r - 1'b1] <= STATE_BITS'(sum);
            end
            tap_r <= tap_r + 1'b1;
            xs_r  <= x_r;
            ys_r  <= y_r;
            acc_r <= '0;
          end
          ud_r <= ud;
        end
        ST_DIVPRE: begin
          neg_r <= acc_r[ACC_W-1] ^ a_r[0][COEF_BITS-1];
          if (nval >= NUM_W'({ud_r, QUO_W'(0)})) begin
            q_r <= '1;
          end else if (nrem >= dtop) begin
            q_r   <= QUO_W'(1);
            rem_r <= nrem - dtop;
            dsh_r <= dtop >> 1;
            cnt_r <= BIT_W'(SAMPLE_BITS-1);
          end else begin
            q_r   <= '0;
            rem_r <= nrem;
            dsh_r <= dtop >> 1;
            cnt_r <= BIT_W'(SAMPLE_BITS-1);
          end
        end
        ST_DIV: begin
          if (rem_r >= dsh_r) begin
            rem_r <= rem_r - dsh_r;
            q_r   <= {q_r[QUO_W-2:0], 1'b1};
          end else begin
            q_r   <= {q_r[QUO_W-2:0], 1'b0};
          end
          dsh_r <= dsh_r >> 1;
          if (cnt_r == '0) cnt_r <= '0;
          else cnt_r <= cnt_r - 1'b1;
        end
        ST_YFIX: begin
          if (neg_r) begin
            if (qc > QUO_W'(1 << (SAMPLE_BITS-1))) begin
              y_r   <= SAMPLE_BITS'(1 << (SAMPLE_BITS-1));
              ys_r  <= SAMPLE_BITS'(1 << (SAMPLE_BITS-1));
              sat_r <= 1'b1;
            end else begin
              y_r   <= SAMPLE_BITS'(-qc);
              ys_r  <= SAMPLE_BITS'(-qc);
            end
          end else begin
            if (qc > QUO_W'((1 << (SAMPLE_BITS-1)) - 1)) begin
              y_r   <= SAMPLE_BITS'((1 << (SAMPLE_BITS-1)) - 1);
              ys_r  <= SAMPLE_BITS'((1 << (SAMPLE_BITS-1)) - 1);
              sat_r <= 1'b1;
            end else begin
              y_r   <= SAMPLE_BITS'(qc);
              ys_r  <= SAMPLE_BITS'(qc);
            end
          end
          tap_r <= TAP_W'(1);
          xs_r  <= x_r;
          acc_r <= '0;
          cnt_r <= '0;
        end
        ST_DONE: begin
          cnt_r <= '0;
          if (load_out) begin
            out_r.sample_out   <= y_r;
            out_r.saturated    <= sat_r;
            out_r.div_by_zero  <= dz_r;
          end
        end
        default: ;
      endcase
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.div_by_zero |-> out_r.sample_out == '0)
    else $error("div_by_zero result with nonzero sample");

  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MAC |-> (TAP_W+1)'(tap_r) < len)
    else $error("tap index beyond length");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.cmd == CMD_SAMPLE |=> !in_ready)
    else $error("sample request did not start work");

  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> cnt_r == '0)
    else $error("bit counter not parked in idle");

endmodule

>>> tb/sv/iir_filter_tdf2_core_tb.sv
// ----------------------------------------------------------------------------
// iir_filter_tdf2_core_tb
// Self-checking regression for the TDF-II IIR core: coefficient loads, delay
// line clears, tap-count settings and sample requests, with a bit-accurate
// filter predictor, random sender bursts, receiver stalls and a long hold-off.
// ----------------------------------------------------------------------------
module iir_filter_tdf2_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iirt2_pkg::*;

  localparam int  SETTLE    = 200;
  localparam int  CYC_LIMIT = 3000000;
  localparam int  HOLD_LEN  = 400;
  localparam longint S48_HI = (longint'(1) <<< 47) - 1;
  localparam longint S48_LO = -(longint'(1) <<< 47);
  localparam longint ONE_Q20 = longint'(1) <<< COEF_FRAC;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_req_t out_data;
  logic cfg_we = 1'b0;
  logic [NTAPS_W-1:0] cfg_wdata = '0;

  iir_filter_tdf2_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // filter model state
  longint b_tab[MAX_TAPS];
  longint a_tab[MAX_TAPS];
  longint zline[MAX_TAPS];
  int     taps_reg;
  bit     clip_flag;
  out_req_t filt_q[$];

  int errors = 0;
  int cyc = 0;
  int burst_left = 0;
  int gap_max = 8;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cnt = 0;

  function automatic longint add_clip(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      clip_flag = 1'b1;
      return 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    if (s < -65'sh0_8000_0000_0000_0000) begin
      clip_flag = 1'b1;
      return 64'sh8000_0000_0000_0000;
    end
    return longint'(s);
  endfunction

  function automatic longint clip48(longint v);
    if (v > S48_HI) begin clip_flag = 1'b1; return S48_HI; end
    if (v < S48_LO) begin clip_flag = 1'b1; return S48_LO; end
    return v;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint unsigned un, ud, q;
    bit neg;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    q = (un + ud / 2) / ud;
    if (neg) begin
      if (q > 32768) begin clip_flag = 1'b1; q = 32768; end
      return -longint'(q);
    end
    if (q > 32767) begin clip_flag = 1'b1; q = 32767; end
    return longint'(q);
  endfunction

  task automatic filter_apply(in_req_t r);
    int len;
    longint x, y, acc;
    out_req_t res;
    case (r.cmd)
      CMD_WR_B: b_tab[r.coef_index] = longint'(r.coef_value);
      CMD_WR_A: a_tab[r.coef_index] = longint'(r.coef_value);
      CMD_CLEAR: foreach (zline[i]) zline[i] = 0;
      default: begin
        len = (taps_reg < 1) ? 1 : (taps_reg > MAX_TAPS) ? MAX_TAPS : taps_reg;
        for (int n = len - 1; n < MAX_TAPS; n++) zline[n] = 0;
        clip_flag = 1'b0;
        res = '0;
        x = longint'(r.sample_in);
        acc = add_clip(b_tab[0] * x, zline[0]);
        if (a_tab[0] == 0) begin
          res.div_by_zero = 1'b1;
          y = 0;
        end else begin
          y = round_div(acc, a_tab[0]);
        end
        for (int n = 1; n < len; n++) begin
          acc = add_clip(b_tab[n] * x, zline[n]);
          acc = add_clip(acc, -(a_tab[n] * y));
          zline[n-1] = clip48(acc);
        end
        zline[len-1] = 0;
        res.sample_out = y[SAMPLE_BITS-1:0];
        res.saturated = clip_flag;
        filt_q.push_back(res);
      end
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n && out_valid && out_ready) begin
      if (filt_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors <= errors + 1;
      end else begin
        if (out_data !== filt_q[0]) begin
          $display("%0t: mismatch expected %p actual %p", $time, filt_q[0], out_data);
          errors <= errors + 1;
        end
        void'(filt_q.pop_front());
      end
    end
  end

  // receiver stall pattern with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      case (cyc[11:10])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= (cyc[4:2] != 3'd0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (cyc > CYC_LIMIT) begin
      $display("iir_filter_tdf2_core regression: fail");
      $finish;
    end
  end

  task automatic send(cmd_t c, logic [15:0] s, logic [2:0] idx, logic [23:0] v);
    in_req_t r;
    r.cmd = c;
    r.sample_in = s;
    r.coef_index = idx;
    r.coef_value = v;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filter_apply(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (filt_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_taps(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v[NTAPS_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    taps_reg = v & 15;
  endtask

  function automatic logic [23:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 24'($urandom());
      1: return 24'(ONE_Q20);
      default: return 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send(CMD_SAMPLE, 16'h7fff, '0, '0);
    send(CMD_SAMPLE, 16'h8000, '0, '0);
    send(CMD_WR_B, '0, '0, 24'(ONE_Q20));
    send(CMD_SAMPLE, 16'h1234, '0, '0);
  endtask

  task automatic test_directed();
    set_taps(8);
    for (int i = 0; i < MAX_TAPS; i++) send(CMD_WR_B, '0, i[2:0], 24'h7fffff);
    send(CMD_WR_A, '0, 3'd7, 24'h800000);
    send(CMD_SAMPLE, 16'h7fff, '0, '0);
    send(CMD_SAMPLE, 16'h8000, '0, '0);
    send(CMD_WR_A, '0, '0, 24'h000001);
    send(CMD_SAMPLE, 16'h7fff, '0, '0);
    send(CMD_SAMPLE, 16'h8000, '0, '0);
    send(CMD_WR_A, '0, '0, 24'h000000);
    send(CMD_SAMPLE, 16'h4000, '0, '0);
    send(CMD_CLEAR, 16'hffff, 3'd7, 24'hffffff);
    send(CMD_WR_A, '0, '0, 24'h800000);
    send(CMD_SAMPLE, 16'h0001, '0, '0);
    send(CMD_SAMPLE, 16'h0000, '0, '0);
    set_taps(0);
    send(CMD_SAMPLE, 16'h8000, '0, '0);
    set_taps(15);
    send(CMD_SAMPLE, 16'hc000, '0, '0);
    send(CMD_SAMPLE, 16'h3fff, '0, '0);
  endtask

  task automatic test_backpressure();
    int keep;
    keep = gap_max;
    gap_max = 0;
    hold_req++;
    for (int i = 0; i < 12; i++) send(CMD_SAMPLE, 16'($urandom()), '0, '0);
    gap_max = keep;
  endtask

  task automatic test_random();
    int taps_set[8] = '{8, 1, 15, 0, 4, 2, 8, 6};
    int n;
    for (int ph = 0; ph < 8; ph++) begin
      set_taps(ph < 6 ? taps_set[ph] : int'($urandom_range(0, 15)));
      gap_max = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 4 : 24;
      n = 0;
      while (n < 110) begin
        if ($urandom_range(0, 9) == 0) begin
          send(cmd_t'($urandom_range(0, 3)), 16'($urandom()), 3'($urandom()),
               24'($urandom()));
          n++;
        end else begin
          send(CMD_WR_A, 16'($urandom()), '0, ($urandom_range(0, 7) == 0) ? rand_coef() :
               24'(ONE_Q20 >>> $urandom_range(0, 2)));
          for (int t = 0; t < MAX_TAPS; t++) begin
            if ($urandom_range(0, 2) != 0) begin
              send(CMD_WR_B, 16'($urandom()), t[2:0], rand_coef());
              n++;
            end
            if (t > 0 && $urandom_range(0, 2) == 0) begin
              send(CMD_WR_A, 16'($urandom()), t[2:0], rand_coef());
              n++;
            end
          end
          if ($urandom_range(0, 1))
            send(CMD_CLEAR, 16'($urandom()), 3'($urandom()), 24'($urandom()));
          repeat ($urandom_range(8, 24)) begin
            send(CMD_SAMPLE, 16'($urandom()), 3'($urandom()), 24'($urandom()));
            n++;
          end
        end
      end
      if (ph == 3) test_backpressure();
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      b_tab[i] = 0;
      a_tab[i] = 0;
      zline[i] = 0;
    end
    a_tab[0] = ONE_Q20;
    taps_reg = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0 && filt_q.size() == 0)
      $display("iir_filter_tdf2_core regression: pass");
    else
      $display("iir_filter_tdf2_core regression: fail");
    $finish;
  end

endmodule
